// ===== rtl/imse_pkg.sv =====
// ----------------------------------------------------------------------------
// imse_pkg
// Shared types and constants of the ir mark/space encoder: the request and
// response words, the configuration set and the segment kinds.
// ----------------------------------------------------------------------------
package imse_pkg;

   localparam int unsigned DUR_W     = 16;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_CODING_MODE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEADER        = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BIT_MARK      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PD_ONE_SPACE  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_PD_ZERO_SPACE = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALT_ONE       = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALT_ZERO      = 3'd6;

   // reset values of the timing registers
   localparam logic [DUR_W-1:0] RST_HEADER        = 16'd3000;
   localparam logic [DUR_W-1:0] RST_BIT_MARK      = 16'd560;
   localparam logic [DUR_W-1:0] RST_PD_ONE_SPACE  = 16'd1600;
   localparam logic [DUR_W-1:0] RST_PD_ZERO_SPACE = 16'd560;
   localparam logic [DUR_W-1:0] RST_ALT_ONE       = 16'd550;
   localparam logic [DUR_W-1:0] RST_ALT_ZERO      = 16'd300;

   // coding modes
   localparam logic MODE_PULSE_DIST = 1'b0;
   localparam logic MODE_ALTERNATE  = 1'b1;

   // input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic       frame_end;
   } req_type;

   // result word, one per segment
   typedef struct packed {
      logic             level;
      logic [DUR_W-1:0] span_us;
      logic             run_last;
   } rsp_type;

   // classified item as it waits between front and back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic       frame_end;
      logic       alt_mode;
   } cmd_type;

   // configuration set, durations already masked
   typedef struct packed {
      logic             coding_mode;
      logic [DUR_W-1:0] header_us;
      logic [DUR_W-1:0] bit_mark_us;
      logic [DUR_W-1:0] pd_one_space_us;
      logic [DUR_W-1:0] pd_zero_space_us;
      logic [DUR_W-1:0] alt_one_us;
      logic [DUR_W-1:0] alt_zero_us;
   } cfg_type;

   // segment kinds of the sequencer
   typedef enum logic [5:0] {
      K_HMARK  = 6'b000001,
      K_HSPACE = 6'b000010,
      K_BMARK  = 6'b000100,
      K_BSPACE = 6'b001000,
      K_BALT   = 6'b010000,
      K_TRAIL  = 6'b100000
   } kind_type;

endpackage

// ===== rtl/ir_mark_space_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// ir_mark_space_encoder_unit
// The first segment of a word reaches the result ports through the input queue,
// then the result queue. Throughput: one segment per cycle from the sequencer
// while the result queue has room, so 8 to 19 segments a word (alternating mode
// without flags to pulse-distance with header/trailer).
// Reset: queues empty, registers to defaults, next alternating bit a mark.
// ----------------------------------------------------------------------------
module ir_mark_space_encoder_unit
   import imse_pkg::*;
#(
   parameter int unsigned DURATION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  req_type               req_word,
   output logic                  req_full,
   output logic                  rsp_empty,
   output rsp_type               rsp_word,
   input  logic                  rsp_pop,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   logic    cmd_valid;
   cmd_type cmd_head;
   logic    cmd_pop;

   // configuration registers
   imse_csr #(
      .DURATION_BITS(DURATION_BITS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   // intake and command queue
   imse_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .alt_mode (cfg.coding_mode),
      .cmd_valid(cmd_valid),
      .cmd_head (cmd_head),
      .cmd_pop  (cmd_pop)
   );

   // segment sequencer and result queue
   imse_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd_valid(cmd_valid),
      .cmd_head (cmd_head),
      .cmd_pop  (cmd_pop),
      .rsp_empty(rsp_empty),
      .rsp_word (rsp_word),
      .rsp_pop  (rsp_pop)
   );

endmodule

// ===== rtl/imse_csr.sv =====
// ----------------------------------------------------------------------------
// imse_csr
// Configuration registers. Durations are kept at the configured duration
// width (at most the 16-bit field) and presented zero-extended.
// ----------------------------------------------------------------------------
module imse_csr
   import imse_pkg::*;
#(
   parameter int unsigned DURATION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   localparam int unsigned REG_W = (DURATION_BITS < DUR_W) ? DURATION_BITS : DUR_W;

   logic             mode_ff;
   logic [REG_W-1:0] header_ff;
   logic [REG_W-1:0] bit_mark_ff;
   logic [REG_W-1:0] pd_one_ff;
   logic [REG_W-1:0] pd_zero_ff;
   logic [REG_W-1:0] alt_one_ff;
   logic [REG_W-1:0] alt_zero_ff;
   logic [REG_W-1:0] wval;

   assign wval = csr_wdata[REG_W-1:0];

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_PULSE_DIST;
         header_ff   <= RST_HEADER[REG_W-1:0];
         bit_mark_ff <= RST_BIT_MARK[REG_W-1:0];
         pd_one_ff   <= RST_PD_ONE_SPACE[REG_W-1:0];
         pd_zero_ff  <= RST_PD_ZERO_SPACE[REG_W-1:0];
         alt_one_ff  <= RST_ALT_ONE[REG_W-1:0];
         alt_zero_ff <= RST_ALT_ZERO[REG_W-1:0];
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CODING_MODE:   mode_ff     <= csr_wdata[0];
            CSR_HEADER:        header_ff   <= wval;
            CSR_BIT_MARK:      bit_mark_ff <= wval;
            CSR_PD_ONE_SPACE:  pd_one_ff   <= wval;
            CSR_PD_ZERO_SPACE: pd_zero_ff  <= wval;
            CSR_ALT_ONE:       alt_one_ff  <= wval;
            CSR_ALT_ZERO:      alt_zero_ff <= wval;
            default: ;
         endcase
      end
   end

   // zero-extend to the field width
   always_comb begin
      cfg                  = '0;
      cfg.coding_mode      = mode_ff;
      cfg.header_us        = DUR_W'(header_ff);
      cfg.bit_mark_us      = DUR_W'(bit_mark_ff);
      cfg.pd_one_space_us  = DUR_W'(pd_one_ff);
      cfg.pd_zero_space_us = DUR_W'(pd_zero_ff);
      cfg.alt_one_us       = DUR_W'(alt_one_ff);
      cfg.alt_zero_us      = DUR_W'(alt_zero_ff);
   end

endmodule

// ===== rtl/imse_front.sv =====
// ----------------------------------------------------------------------------
// imse_front
// Accepts input words, tags each with the coding mode and holds them in a
// two-entry queue for the segment sequencer.
// ----------------------------------------------------------------------------
module imse_front
   import imse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_word,
   output logic    req_full,
   input  logic    alt_mode,
   output logic    cmd_valid,
   output cmd_type cmd_head,
   input  logic    cmd_pop
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;
   logic       pop_ok;
   cmd_type    cmd_new;

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_head  = mem_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   // classify the incoming word
   always_comb begin
      cmd_new             = '0;
      cmd_new.data_byte   = req_word.data_byte;
      cmd_new.frame_start = req_word.frame_start;
      cmd_new.frame_end   = req_word.frame_end;
      cmd_new.alt_mode    = (alt_mode == MODE_ALTERNATE);
   end

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== rtl/imse_seq.sv =====
// ----------------------------------------------------------------------------
// imse_seq
// Segment sequencer: walks header, bits and trailer of the queued item, one
// segment per cycle while the result queue has room, into a two-entry result
// queue. Keeps the alternating level across items.
// ----------------------------------------------------------------------------
module imse_seq
   import imse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd_head,
   output logic    cmd_pop,
   output logic    rsp_empty,
   output rsp_type rsp_word,
   input  logic    rsp_pop
);

   kind_type   kind_ff, kind_in;
   logic       busy_ff, busy_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;
   logic       alt_ff, alt_in;

   kind_type   cur_kind;
   kind_type   next_kind;
   logic       bit_val;
   logic       bit_done;
   logic       seg_level;
   logic [DUR_W-1:0] seg_dur;
   logic       seg_last;
   logic       bit_adv;
   logic       alt_tog;
   logic       fire;

   rsp_type    oq_ff [2];
   logic       oq_wr_ff, oq_wr_in;
   logic       oq_rd_ff, oq_rd_in;
   logic [1:0] oq_cnt_ff, oq_cnt_in;
   logic       oq_pop;
   rsp_type    seg_word;

   assign fire     = cmd_valid && (oq_cnt_ff != 2'd2);
   assign cmd_pop  = fire && seg_last;
   assign bit_val  = cmd_head.data_byte[3'd7 - bit_cnt_ff];
   assign bit_done = (bit_cnt_ff == 3'd7);

   // segment selection
   always_comb begin
      if (busy_ff) begin
         cur_kind = kind_ff;
      end else if (cmd_head.frame_start) begin
         cur_kind = K_HMARK;
      end else if (cmd_head.alt_mode) begin
         cur_kind = K_BALT;
      end else begin
         cur_kind = K_BMARK;
      end

      seg_level = 1'b1;
      seg_dur   = cfg.header_us;
      seg_last  = 1'b0;
      next_kind = K_HSPACE;
      bit_adv   = 1'b0;
      alt_tog   = 1'b0;

      case (cur_kind)
         K_HMARK: begin
            seg_level = 1'b1;
            seg_dur   = cfg.header_us;
            next_kind = K_HSPACE;
         end
         K_HSPACE: begin
            seg_level = 1'b0;
            seg_dur   = cfg.header_us;
            next_kind = cmd_head.alt_mode ? K_BALT : K_BMARK;
         end
         K_BMARK: begin
            seg_level = 1'b1;
            seg_dur   = cfg.bit_mark_us;
            next_kind = K_BSPACE;
         end
         K_BSPACE: begin
            seg_level = 1'b0;
            seg_dur   = bit_val ? cfg.pd_one_space_us : cfg.pd_zero_space_us;
            bit_adv   = 1'b1;
            seg_last  = bit_done && !cmd_head.frame_end;
            next_kind = bit_done ? K_TRAIL : K_BMARK;
         end
         K_BALT: begin
            seg_level = ~alt_ff;
            seg_dur   = bit_val ? cfg.alt_one_us : cfg.alt_zero_us;
            bit_adv   = 1'b1;
            alt_tog   = 1'b1;
            seg_last  = bit_done && !cmd_head.frame_end;
            next_kind = bit_done ? K_TRAIL : K_BALT;
         end
         K_TRAIL: begin
            seg_level = 1'b1;
            seg_dur   = cmd_head.alt_mode ? cfg.alt_zero_us : cfg.bit_mark_us;
            seg_last  = 1'b1;
            next_kind = K_TRAIL;
         end
         default: begin
            seg_last  = 1'b1;
            next_kind = K_HMARK;
         end
      endcase
   end

   // sequencer state update
   always_comb begin
      kind_in    = kind_ff;
      busy_in    = busy_ff;
      bit_cnt_in = bit_cnt_ff;
      alt_in     = alt_ff;
      if (fire) begin
         alt_in = alt_ff ^ alt_tog;
         if (seg_last) begin
            busy_in    = 1'b0;
            bit_cnt_in = 3'd0;
         end else begin
            busy_in    = 1'b1;
            kind_in    = next_kind;
            bit_cnt_in = bit_adv ? bit_cnt_ff + 3'd1 : bit_cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= K_HMARK;
         busy_ff    <= 1'b0;
         bit_cnt_ff <= 3'd0;
         alt_ff     <= 1'b0;
      end else begin
         kind_ff    <= kind_in;
         busy_ff    <= busy_in;
         bit_cnt_ff <= bit_cnt_in;
         alt_ff     <= alt_in;
      end
   end

   // result queue
   always_comb begin
      seg_word          = '0;
      seg_word.level    = seg_level;
      seg_word.span_us  = seg_dur;
      seg_word.run_last = seg_last;
   end

   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign rsp_word  = oq_ff[oq_rd_ff];
   assign oq_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      oq_wr_in  = fire ? ~oq_wr_ff : oq_wr_ff;
      oq_rd_in  = oq_pop ? ~oq_rd_ff : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff;
      if (fire && !oq_pop) begin
         oq_cnt_in = oq_cnt_ff + 2'd1;
      end else if (!fire && oq_pop) begin
         oq_cnt_in = oq_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         oq_ff[oq_wr_ff] <= seg_word;
      end
   end

endmodule
